// ===== rtl/pid_position_motor_controller_assert.svh =====
// ----------------------------------------------------------------------------
// PID position motor controller assertion macros
// Shared property forms used by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_MOTOR_CONTROLLER_ASSERT_SVH
`define PID_POSITION_MOTOR_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmc assertion failed: same-cycle property");

// The consequent must hold in the cycle after the antecedent.
`define PMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmc assertion failed: next-cycle property");

`endif

// ===== rtl/pmc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID position motor controller package
// Shared widths, register indexes, controller states and command types.
// ----------------------------------------------------------------------------
package pmc_pkg;

   localparam int FRAC_BITS_DEF  = 8;
   localparam int POS_WIDTH_DEF  = 32;
   localparam int GAIN_WIDTH     = 12;
   localparam int SETPOINT_WIDTH = 9;
   localparam int DELTA_WIDTH    = 16;
   localparam int DRIVE_WIDTH    = 16;
   localparam int OUT_WIDTH      = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_IDX_WIDTH  = 3;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_GAIN_P     = 3'd0,
      REG_GAIN_I     = 3'd1,
      REG_GAIN_D     = 3'd2,
      REG_SETPOINT   = 3'd3,
      REG_HOLD_MOTOR = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS,
      ST_ERR,
      ST_DIFF,
      ST_DIVSET,
      ST_DIV,
      ST_INTEG,
      ST_MUL_P_LO,
      ST_MUL_P_HI,
      ST_MUL_D_LO,
      ST_MUL_D_HI,
      ST_MUL_I,
      ST_SCALE,
      ST_ROUND,
      ST_SHAPE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      MUL_P_LO,
      MUL_P_HI,
      MUL_D_LO,
      MUL_D_HI,
      MUL_I
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD_LO,
      ACC_ADD_HI
   } acc_op_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0]            gain_p;
      logic [GAIN_WIDTH-1:0]            gain_i;
      logic [GAIN_WIDTH-1:0]            gain_d;
      logic signed [SETPOINT_WIDTH-1:0] setpoint;
      logic                             hold_motor;
   } cfg_type;

   typedef struct packed {
      logic        load_in;
      logic        pos_upd;
      logic        err_upd;
      logic        diff_upd;
      logic        div_init;
      logic        div_step;
      logic        int_upd;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        scale;
      logic        round;
      logic        out_load;
   } ctrl_cmd_type;

endpackage

// ===== rtl/pid_position_motor_controller.sv =====
// ----------------------------------------------------------------------------
// PID position motor controller
// Positional PID with a variable-rate integral, dead zone, friction offset
// and output clamp, processing one encoder sample per control period.
// ----------------------------------------------------------------------------
// Each accepted request is one control period: the encoder delta is added to
// the saturating position, the error against the setpoint is formed, and one
// result carrying the drive, position and error is returned. A request is
// not taken until the sequencer has gone back to idle after the previous one;
// the bit-serial divider of the integral step, one quotient bit per cycle,
// and the single shared gain multiplier, used in five passes, lengthen the
// sequence. A finished result waits in its own register, so the next request
// is accepted while the previous result is still pending. Configuration
// must be written through the APB-style port only while no request is in
// progress; the block itself does not enforce this.
module pid_position_motor_controller #(
   parameter int FRAC_BITS = pmc_pkg::FRAC_BITS_DEF,
   parameter int POS_WIDTH = pmc_pkg::POS_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [pmc_pkg::DELTA_WIDTH-1:0]  req_encoder_delta,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pmc_pkg::DRIVE_WIDTH-1:0]  rsp_drive_q8,
   output logic signed [pmc_pkg::OUT_WIDTH-1:0]    rsp_position_now,
   output logic signed [pmc_pkg::OUT_WIDTH-1:0]    rsp_error_now,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [pmc_pkg::CSR_ADDR_WIDTH-1:0]      paddr,
   input  logic [pmc_pkg::CSR_DATA_WIDTH-1:0]      pwdata,
   output logic [pmc_pkg::CSR_DATA_WIDTH-1:0]      prdata,
   output logic                                    pready
);

   pmc_pkg::cfg_type      cfg;
   pmc_pkg::ctrl_cmd_type cmd;

   pmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pmc_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pmc_dp #(
      .FRAC_BITS (FRAC_BITS),
      .POS_WIDTH (POS_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_encoder_delta (req_encoder_delta),
      .rsp_drive_q8      (rsp_drive_q8),
      .rsp_position_now  (rsp_position_now),
      .rsp_error_now     (rsp_error_now)
   );

endmodule

// ===== rtl/pmc_csr.sv =====
// ----------------------------------------------------------------------------
// PID position motor controller register file
// APB-style configuration registers with write decode and read back.
// ----------------------------------------------------------------------------
module pmc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pmc_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [pmc_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [pmc_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready,
   output pmc_pkg::cfg_type                    cfg
);

   pmc_pkg::cfg_type      cfg_ff;
   pmc_pkg::cfg_type      cfg_in;
   pmc_pkg::csr_index_type index;
   logic                  wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign index  = pmc_pkg::csr_index_type'(paddr[pmc_pkg::CSR_ADDR_WIDTH-1:2]);
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            pmc_pkg::REG_GAIN_P: begin
               cfg_in.gain_p = pwdata[pmc_pkg::GAIN_WIDTH-1:0];
            end
            pmc_pkg::REG_GAIN_I: begin
               cfg_in.gain_i = pwdata[pmc_pkg::GAIN_WIDTH-1:0];
            end
            pmc_pkg::REG_GAIN_D: begin
               cfg_in.gain_d = pwdata[pmc_pkg::GAIN_WIDTH-1:0];
            end
            pmc_pkg::REG_SETPOINT: begin
               cfg_in.setpoint = $signed(pwdata[pmc_pkg::SETPOINT_WIDTH-1:0]);
            end
            pmc_pkg::REG_HOLD_MOTOR: begin
               cfg_in.hold_motor = pwdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         pmc_pkg::REG_GAIN_P: begin
            prdata = pmc_pkg::CSR_DATA_WIDTH'(cfg_ff.gain_p);
         end
         pmc_pkg::REG_GAIN_I: begin
            prdata = pmc_pkg::CSR_DATA_WIDTH'(cfg_ff.gain_i);
         end
         pmc_pkg::REG_GAIN_D: begin
            prdata = pmc_pkg::CSR_DATA_WIDTH'(cfg_ff.gain_d);
         end
         pmc_pkg::REG_SETPOINT: begin
            prdata = pmc_pkg::CSR_DATA_WIDTH'(cfg_ff.setpoint);
         end
         pmc_pkg::REG_HOLD_MOTOR: begin
            prdata = pmc_pkg::CSR_DATA_WIDTH'(cfg_ff.hold_motor);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/pmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// PID position motor controller sequencer
// State machine that steps the datapath through one control period and
// owns the request and result handshakes.
// ----------------------------------------------------------------------------
`include "pid_position_motor_controller_assert.svh"

module pmc_ctrl #(
   parameter int FRAC_BITS = pmc_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pmc_pkg::ctrl_cmd_type cmd
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   pmc_pkg::ctrl_state_type state_ff;
   pmc_pkg::ctrl_state_type state_in;
   logic [CNT_W-1:0]        div_cnt_ff;
   logic [CNT_W-1:0]        div_cnt_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pmc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pmc_pkg::ST_POS;
            end
         end
         pmc_pkg::ST_POS:      state_in = pmc_pkg::ST_ERR;
         pmc_pkg::ST_ERR:      state_in = pmc_pkg::ST_DIFF;
         pmc_pkg::ST_DIFF:     state_in = pmc_pkg::ST_DIVSET;
         pmc_pkg::ST_DIVSET:   state_in = pmc_pkg::ST_DIV;
         pmc_pkg::ST_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = pmc_pkg::ST_INTEG;
            end
         end
         pmc_pkg::ST_INTEG:    state_in = pmc_pkg::ST_MUL_P_LO;
         pmc_pkg::ST_MUL_P_LO: state_in = pmc_pkg::ST_MUL_P_HI;
         pmc_pkg::ST_MUL_P_HI: state_in = pmc_pkg::ST_MUL_D_LO;
         pmc_pkg::ST_MUL_D_LO: state_in = pmc_pkg::ST_MUL_D_HI;
         pmc_pkg::ST_MUL_D_HI: state_in = pmc_pkg::ST_MUL_I;
         pmc_pkg::ST_MUL_I:    state_in = pmc_pkg::ST_SCALE;
         pmc_pkg::ST_SCALE:    state_in = pmc_pkg::ST_ROUND;
         pmc_pkg::ST_ROUND:    state_in = pmc_pkg::ST_SHAPE;
         pmc_pkg::ST_SHAPE: begin
            if (out_free) begin
               state_in = pmc_pkg::ST_IDLE;
            end
         end
         default:              state_in = pmc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.load_in  = 1'b0;
      cmd.pos_upd  = 1'b0;
      cmd.err_upd  = 1'b0;
      cmd.diff_upd = 1'b0;
      cmd.div_init = 1'b0;
      cmd.div_step = 1'b0;
      cmd.int_upd  = 1'b0;
      cmd.mul_en   = 1'b0;
      cmd.mul_sel  = pmc_pkg::MUL_I;
      cmd.acc_op   = pmc_pkg::ACC_HOLD;
      cmd.scale    = 1'b0;
      cmd.round    = 1'b0;
      cmd.out_load = 1'b0;
      div_cnt_in   = div_cnt_ff;
      unique case (state_ff)
         pmc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         pmc_pkg::ST_POS: begin
            cmd.pos_upd = 1'b1;
         end
         pmc_pkg::ST_ERR: begin
            cmd.err_upd = 1'b1;
         end
         pmc_pkg::ST_DIFF: begin
            cmd.diff_upd = 1'b1;
         end
         pmc_pkg::ST_DIVSET: begin
            cmd.div_init = 1'b1;
            div_cnt_in   = CNT_W'(FRAC_BITS);
         end
         pmc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff - CNT_W'(1);
         end
         pmc_pkg::ST_INTEG: begin
            cmd.int_upd = 1'b1;
         end
         pmc_pkg::ST_MUL_P_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pmc_pkg::MUL_P_LO;
            cmd.acc_op  = pmc_pkg::ACC_CLEAR;
         end
         pmc_pkg::ST_MUL_P_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pmc_pkg::MUL_P_HI;
            cmd.acc_op  = pmc_pkg::ACC_ADD_LO;
         end
         pmc_pkg::ST_MUL_D_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pmc_pkg::MUL_D_LO;
            cmd.acc_op  = pmc_pkg::ACC_ADD_HI;
         end
         pmc_pkg::ST_MUL_D_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pmc_pkg::MUL_D_HI;
            cmd.acc_op  = pmc_pkg::ACC_ADD_LO;
         end
         pmc_pkg::ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pmc_pkg::MUL_I;
            cmd.acc_op  = pmc_pkg::ACC_ADD_HI;
         end
         pmc_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
         end
         pmc_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
         end
         pmc_pkg::ST_SHAPE: begin
            cmd.out_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmc_pkg::ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PMC_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == pmc_pkg::ST_POS)
   `PMC_ASSERT_NEXT(a_div_ends, clock, reset, (state_ff == pmc_pkg::ST_DIV) && (div_cnt_ff == '0), state_ff == pmc_pkg::ST_INTEG)
   `PMC_ASSERT_SAME(a_rsp_from_shape, clock, reset, $rose(rsp_valid_ff), $past(state_ff == pmc_pkg::ST_SHAPE))
   `PMC_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready)

endmodule

// ===== rtl/pmc_dp.sv =====
// ----------------------------------------------------------------------------
// PID position motor controller datapath
// Position and error registers, bit-serial divider for the integral step,
// shared gain multiplier with accumulator, rounding and drive shaping.
// ----------------------------------------------------------------------------
`include "pid_position_motor_controller_assert.svh"

module pmc_dp #(
   parameter int FRAC_BITS = pmc_pkg::FRAC_BITS_DEF,
   parameter int POS_WIDTH = pmc_pkg::POS_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pmc_pkg::ctrl_cmd_type                   cmd,
   input  pmc_pkg::cfg_type                        cfg,
   input  logic signed [pmc_pkg::DELTA_WIDTH-1:0]  req_encoder_delta,
   output logic signed [pmc_pkg::DRIVE_WIDTH-1:0]  rsp_drive_q8,
   output logic signed [pmc_pkg::OUT_WIDTH-1:0]    rsp_position_now,
   output logic signed [pmc_pkg::OUT_WIDTH-1:0]    rsp_error_now
);

   localparam int PW  = POS_WIDTH;
   localparam int DEW = PW + 1;
   localparam int LW  = DEW / 2;
   localparam int HW  = DEW - LW;
   localparam int IW  = FRAC_BITS + 10;
   localparam int QW  = FRAC_BITS + 1;
   localparam int MB1 = (LW + 1 > HW) ? LW + 1 : HW;
   localparam int MBW = (MB1 > IW) ? MB1 : IW;
   localparam int GW  = pmc_pkg::GAIN_WIDTH + 1;
   localparam int PRW = MBW + GW;
   localparam int AW  = PW + 15;
   localparam int CW  = (AW > 42) ? AW : 42;
   localparam int TW  = FRAC_BITS + 43;
   localparam int DRW = TW - 9;
   localparam int NW  = FRAC_BITS + 37;
   localparam int AMW = (PW > 31) ? PW : 31;
   localparam int EW  = (PW > 32) ? PW : 33;
   localparam int MW  = 31;

   localparam logic signed [PW-1:0]   POS_MAX  = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0]   POS_MIN  = {1'b1, {(PW-1){1'b0}}};
   localparam logic signed [PW-1:0]   DZ_LIM   = PW'(4);
   localparam logic [AMW-1:0]         M_CAP    = AMW'(1 << 30);
   localparam logic signed [IW:0]     INT_LIMW = (IW+1)'(500 * (1 << FRAC_BITS));
   localparam logic signed [IW-1:0]   INT_LIM  = IW'(500 * (1 << FRAC_BITS));
   localparam logic signed [CW-1:0]   BIG_LIM  = CW'(1) <<< 40;
   localparam logic signed [DRW-1:0]  DRV_LIM  = DRW'(100 * (1 << FRAC_BITS));
   localparam logic signed [DRW-1:0]  DRV_BIG  = DRW'(200 * (1 << FRAC_BITS));
   localparam logic signed [DRW-1:0]  FRIC_OFS = DRW'(5 * (1 << FRAC_BITS));
   localparam logic signed [DRW-1:0]  FRIC_THR = DRW'((1 << FRAC_BITS) / 10);
   localparam logic signed [EW-1:0]   O_MAX    = EW'(64'sh7FFF_FFFF);
   localparam logic signed [EW-1:0]   O_MIN    = -O_MAX - EW'(1);

   function automatic logic signed [PW-1:0] sat_pw(input logic signed [PW:0] v);
      logic signed [PW-1:0] r;
      if (v[PW] != v[PW-1]) begin
         r = v[PW] ? POS_MIN : POS_MAX;
      end else begin
         r = v[PW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
      logic signed [EW-1:0] x;
      logic signed [31:0]   r;
      x = EW'(v);
      if (x > O_MAX) begin
         r = O_MAX[31:0];
      end else if (x < O_MIN) begin
         r = O_MIN[31:0];
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   logic signed [pmc_pkg::DELTA_WIDTH-1:0] delta_ff;
   logic signed [PW-1:0]  position_ff;
   logic signed [PW-1:0]  last_error_ff;
   logic signed [IW-1:0]  integral_ff;
   logic signed [PW-1:0]  e_ff;
   logic signed [DEW-1:0] de_ff;
   logic [MW-1:0]         m_ff;
   logic [NW-1:0]         rem_ff;
   logic [NW-1:0]         dsr_ff;
   logic [QW-1:0]         q_ff;
   logic signed [PRW-1:0] prod_ff;
   logic signed [AW-1:0]  acc_ff;
   logic signed [TW-1:0]  t_ff;
   logic                  big_pos_ff;
   logic                  big_neg_ff;
   logic signed [DRW-1:0] drive_ff;
   logic signed [pmc_pkg::DRIVE_WIDTH-1:0] out_drive_ff;
   logic signed [pmc_pkg::OUT_WIDTH-1:0]   out_pos_ff;
   logic signed [pmc_pkg::OUT_WIDTH-1:0]   out_err_ff;

   logic signed [PW:0]    pos_sum;
   logic signed [PW:0]    err_sum;
   logic [PW-1:0]         e_abs;
   logic [AMW-1:0]        e_abs_x;
   logic [NW-1:0]         m_n;
   logic [NW-1:0]         den_n;
   logic [NW-1:0]         rem_in;
   logic [NW-1:0]         dsr_in;
   logic [QW-1:0]         q_in;
   logic signed [IW:0]    q_s;
   logic signed [IW:0]    i_sum;
   logic signed [IW-1:0]  integral_in;
   logic signed [DEW-1:0] e_x;
   logic signed [GW-1:0]  a_op;
   logic signed [MBW-1:0] b_op;
   logic signed [PRW-1:0] prod_in;
   logic signed [AW-1:0]  acc_in;
   logic signed [CW-1:0]  acc_c;
   logic signed [TW-1:0]  t_in;
   logic [TW-1:0]         t_mag;
   logic [TW-1:0]         t_rnd;
   logic signed [DRW-1:0] r_s;
   logic signed [DRW-1:0] drive_in;
   logic                  dz;
   logic signed [DRW-1:0] fric;
   logic signed [DRW-1:0] shaped;

   assign pos_sum = (PW+1)'(position_ff) + (PW+1)'(delta_ff);
   assign err_sum = (PW+1)'(cfg.setpoint) - (PW+1)'(position_ff);

   assign e_abs   = e_ff[PW-1] ? PW'(-e_ff) : PW'(e_ff);
   assign e_abs_x = AMW'(e_abs);

   assign m_n    = NW'(m_ff);
   assign den_n  = (m_n << 3) - m_n + NW'(10);
   assign rem_in = cmd.div_init ? (((m_n << 4) + (m_n << 2)) << FRAC_BITS) + den_n
                 : ((rem_ff >= dsr_ff) ? rem_ff - dsr_ff : rem_ff);
   assign dsr_in = cmd.div_init ? den_n << (FRAC_BITS + 1) : dsr_ff >> 1;
   assign q_in   = cmd.div_init ? '0 : {q_ff[QW-2:0], rem_ff >= dsr_ff};

   assign q_s   = $signed({{(IW+1-QW){1'b0}}, q_ff});
   assign i_sum = e_ff[PW-1] ? (IW+1)'(integral_ff) - q_s : (IW+1)'(integral_ff) + q_s;

   always_comb begin
      if (cfg.gain_i == '0) begin
         integral_in = '0;
      end else if (i_sum > INT_LIMW) begin
         integral_in = INT_LIMW[IW-1:0];
      end else if (i_sum < -INT_LIMW) begin
         integral_in = IW'(-INT_LIMW);
      end else begin
         integral_in = i_sum[IW-1:0];
      end
   end

   assign e_x = DEW'(e_ff);

   always_comb begin
      case (cmd.mul_sel)
         pmc_pkg::MUL_P_LO: begin
            a_op = $signed({1'b0, cfg.gain_p});
            b_op = $signed({{(MBW-LW){1'b0}}, e_x[LW-1:0]});
         end
         pmc_pkg::MUL_P_HI: begin
            a_op = $signed({1'b0, cfg.gain_p});
            b_op = MBW'($signed(e_x[DEW-1:LW]));
         end
         pmc_pkg::MUL_D_LO: begin
            a_op = $signed({1'b0, cfg.gain_d});
            b_op = $signed({{(MBW-LW){1'b0}}, de_ff[LW-1:0]});
         end
         pmc_pkg::MUL_D_HI: begin
            a_op = $signed({1'b0, cfg.gain_d});
            b_op = MBW'($signed(de_ff[DEW-1:LW]));
         end
         default: begin
            a_op = $signed({1'b0, cfg.gain_i});
            b_op = MBW'(integral_ff);
         end
      endcase
   end

   assign prod_in = a_op * b_op;

   always_comb begin
      case (cmd.acc_op)
         pmc_pkg::ACC_CLEAR:  acc_in = '0;
         pmc_pkg::ACC_ADD_LO: acc_in = acc_ff + AW'(prod_ff);
         pmc_pkg::ACC_ADD_HI: acc_in = acc_ff + (AW'(prod_ff) <<< LW);
         default:             acc_in = acc_ff;
      endcase
   end

   assign acc_c = CW'(acc_ff);
   assign t_in  = (TW'(acc_ff) <<< FRAC_BITS) + TW'(prod_ff);

   assign t_mag = t_ff[TW-1] ? TW'(-t_ff) : TW'(t_ff);
   assign t_rnd = t_mag + TW'(1024);
   assign r_s   = $signed(DRW'(t_rnd[TW-1:11]));

   always_comb begin
      if (big_pos_ff) begin
         drive_in = DRV_BIG;
      end else if (big_neg_ff) begin
         drive_in = -DRV_BIG;
      end else if (t_ff[TW-1]) begin
         drive_in = -r_s;
      end else begin
         drive_in = r_s;
      end
   end

   assign dz = (e_ff < DZ_LIM) && (e_ff > -DZ_LIM);

   always_comb begin
      if (dz) begin
         fric = '0;
      end else if (drive_ff > FRIC_THR) begin
         fric = drive_ff + FRIC_OFS;
      end else if (drive_ff < -FRIC_THR) begin
         fric = drive_ff - FRIC_OFS;
      end else begin
         fric = '0;
      end
      if (cfg.hold_motor) begin
         shaped = '0;
      end else if (fric > DRV_LIM) begin
         shaped = DRV_LIM;
      end else if (fric < -DRV_LIM) begin
         shaped = -DRV_LIM;
      end else begin
         shaped = fric;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         last_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         if (cmd.pos_upd) begin
            position_ff <= sat_pw(pos_sum);
         end
         if (cmd.diff_upd) begin
            last_error_ff <= e_ff;
         end
         if (cmd.int_upd) begin
            integral_ff <= integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         delta_ff <= req_encoder_delta;
      end
      if (cmd.err_upd) begin
         e_ff <= sat_pw(err_sum);
      end
      if (cmd.diff_upd) begin
         de_ff <= DEW'(e_ff) - DEW'(last_error_ff);
         m_ff  <= MW'((e_abs_x > M_CAP) ? M_CAP : e_abs_x);
      end
      if (cmd.div_init || cmd.div_step) begin
         rem_ff <= rem_in;
         dsr_ff <= dsr_in;
         q_ff   <= q_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.scale) begin
         t_ff       <= t_in;
         big_pos_ff <= acc_c > BIG_LIM;
         big_neg_ff <= acc_c < -BIG_LIM;
      end
      if (cmd.round) begin
         drive_ff <= drive_in;
      end
      if (cmd.out_load) begin
         out_drive_ff <= shaped[pmc_pkg::DRIVE_WIDTH-1:0];
         out_pos_ff   <= sat32(position_ff);
         out_err_ff   <= sat32(e_ff);
      end
   end

   assign rsp_drive_q8     = out_drive_ff;
   assign rsp_position_now = out_pos_ff;
   assign rsp_error_now    = out_err_ff;

   `PMC_ASSERT_SAME(a_integral_bound, clock, reset, 1'b1, (integral_ff <= INT_LIM) && (integral_ff >= -INT_LIM))
   `PMC_ASSERT_NEXT(a_integral_cleared, clock, reset, cmd.int_upd && (cfg.gain_i == '0), integral_ff == '0)

endmodule

// ===== tb/pid_position_motor_controller_test.sv =====
// ----------------------------------------------------------------------------
// PID position motor controller testbench
// Drives encoder samples and register settings into the controller. A
// scoreboard predicts the drive, position and error of every control period
// and checks each result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class motor_scoreboard;

   typedef struct packed {
      logic signed [pmc_pkg::DRIVE_WIDTH-1:0] drive;
      logic signed [pmc_pkg::OUT_WIDTH-1:0]   position;
      logic signed [pmc_pkg::OUT_WIDTH-1:0]   error;
   } period_result_type;

   localparam longint FRAC               = pmc_pkg::FRAC_BITS_DEF;
   localparam longint ONE_Q              = 64'sd1 <<< FRAC;
   localparam longint POS_MAX            = 64'sd2147483647;
   localparam longint POS_MIN            = -64'sd2147483648;
   localparam longint MAG_LIMIT          = 64'sd1 <<< 30;
   localparam longint BIG_LIMIT          = 64'sd1 <<< 40;
   localparam longint INT_LIMIT          = 500 * ONE_Q;
   localparam longint DRIVE_LIMIT        = 100 * ONE_Q;
   localparam longint FRICTION_OFFSET    = 5 * ONE_Q;
   localparam longint FRICTION_THRESHOLD = ONE_Q / 10;
   localparam longint DEAD_ZONE          = 4;
   localparam longint GAIN_SCALE         = 2048;
   localparam int     PRINT_LIMIT        = 64;

   logic [pmc_pkg::GAIN_WIDTH-1:0]            gain_p = '0;
   logic [pmc_pkg::GAIN_WIDTH-1:0]            gain_i = '0;
   logic [pmc_pkg::GAIN_WIDTH-1:0]            gain_d = '0;
   logic signed [pmc_pkg::SETPOINT_WIDTH-1:0] target = '0;
   logic                                      hold = 1'b0;
   longint                                    position = 0;
   longint                                    last_error = 0;
   longint                                    integral = 0;
   int                                        errors = 0;
   period_result_type                         expected[$];

   static function longint saturate(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   static function longint magnitude(longint x);
      return x < 0 ? -x : x;
   endfunction

   function int pending();
      return expected.size();
   endfunction

   task report(string what);
      if (errors < PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s", $realtime, what);
      end
      errors++;
   endtask

   function void write_register(int unsigned index, logic [31:0] value);
      case (index)
         pmc_pkg::REG_GAIN_P:     gain_p = value[pmc_pkg::GAIN_WIDTH-1:0];
         pmc_pkg::REG_GAIN_I:     gain_i = value[pmc_pkg::GAIN_WIDTH-1:0];
         pmc_pkg::REG_GAIN_D:     gain_d = value[pmc_pkg::GAIN_WIDTH-1:0];
         pmc_pkg::REG_SETPOINT:   target = value[pmc_pkg::SETPOINT_WIDTH-1:0];
         pmc_pkg::REG_HOLD_MOTOR: hold = value[0];
         default: ;
      endcase
   endfunction

   function void note_encoder_delta(logic signed [pmc_pkg::DELTA_WIDTH-1:0] delta);
      longint err, err_step, mag, num, den, step, p_d_sum, total, drive;
      period_result_type want;
      position = saturate(position + longint'(delta), POS_MIN, POS_MAX);
      err = saturate(longint'(target) - position, POS_MIN, POS_MAX);
      err_step = err - last_error;
      last_error = err;
      if (gain_i != 0) begin
         mag = magnitude(err);
         if (mag > MAG_LIMIT) mag = MAG_LIMIT;
         num = (10 * mag) <<< FRAC;
         den = 7 * mag + 10;
         step = (2 * num + den) / (2 * den);
         integral = saturate(integral + (err < 0 ? -step : step), -INT_LIMIT, INT_LIMIT);
      end else begin
         integral = 0;
      end
      p_d_sum = longint'(gain_p) * err + longint'(gain_d) * err_step;
      if (p_d_sum > BIG_LIMIT) begin
         drive = 2 * DRIVE_LIMIT;
      end else if (p_d_sum < -BIG_LIMIT) begin
         drive = -2 * DRIVE_LIMIT;
      end else begin
         total = p_d_sum * ONE_Q + longint'(gain_i) * integral;
         drive = (magnitude(total) + GAIN_SCALE / 2) / GAIN_SCALE;
         if (total < 0) drive = -drive;
      end
      if (magnitude(err) < DEAD_ZONE) drive = 0;
      if (drive > FRICTION_THRESHOLD) begin
         drive += FRICTION_OFFSET;
      end else if (drive < -FRICTION_THRESHOLD) begin
         drive -= FRICTION_OFFSET;
      end else begin
         drive = 0;
      end
      drive = saturate(drive, -DRIVE_LIMIT, DRIVE_LIMIT);
      if (hold) drive = 0;
      want.drive = pmc_pkg::DRIVE_WIDTH'(drive);
      want.position = pmc_pkg::OUT_WIDTH'(position);
      want.error = pmc_pkg::OUT_WIDTH'(err);
      expected.push_back(want);
   endfunction

   task check_drive_result(logic signed [pmc_pkg::DRIVE_WIDTH-1:0] drive,
                           logic signed [pmc_pkg::OUT_WIDTH-1:0] pos,
                           logic signed [pmc_pkg::OUT_WIDTH-1:0] err);
      period_result_type want;
      if (expected.size() == 0) begin
         report($sformatf("result with nothing pending: drive %0d position %0d", drive, pos));
         return;
      end
      want = expected.pop_front();
      if (drive !== want.drive) begin
         report($sformatf("drive %0d, expected %0d", drive, want.drive));
      end
      if (pos !== want.position) begin
         report($sformatf("position %0d, expected %0d", pos, want.position));
      end
      if (err !== want.error) begin
         report($sformatf("error %0d, expected %0d", err, want.error));
      end
   endtask

endclass

module pid_position_motor_controller_test;

   localparam int CSR_STRIDE           = 4;
   localparam int FIRST_UNMAPPED_INDEX = pmc_pkg::REG_HOLD_MOTOR + 1;
   localparam int GAIN_MAX             = (1 << pmc_pkg::GAIN_WIDTH) - 1;
   localparam int SETPOINT_LIMIT       = 150;
   localparam int IDLE_PERCENT         = 13;
   localparam int SEGMENTS             = 12;
   localparam int SEGMENT_ITEMS        = 144;
   localparam int SWING_ITEMS          = 12;
   localparam int DRAIN_CYCLES         = 40;

   logic                                      clock;
   logic                                      reset = 1'b1;
   logic                                      req_valid = 1'b0;
   logic                                      req_ready;
   logic signed [pmc_pkg::DELTA_WIDTH-1:0]    req_encoder_delta = '0;
   logic                                      rsp_valid;
   logic                                      rsp_ready = 1'b0;
   logic signed [pmc_pkg::DRIVE_WIDTH-1:0]    rsp_drive_q8;
   logic signed [pmc_pkg::OUT_WIDTH-1:0]      rsp_position_now;
   logic signed [pmc_pkg::OUT_WIDTH-1:0]      rsp_error_now;
   logic                                      psel = 1'b0;
   logic                                      penable = 1'b0;
   logic                                      pwrite = 1'b0;
   logic [pmc_pkg::CSR_ADDR_WIDTH-1:0]        paddr = '0;
   logic [pmc_pkg::CSR_DATA_WIDTH-1:0]        pwdata = '0;
   logic [pmc_pkg::CSR_DATA_WIDTH-1:0]        prdata;
   logic                                      pready;

   bit                                        idle_on = 1'b1;
   motor_scoreboard                           sb = new();

   pid_position_motor_controller dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_drive_result(rsp_drive_q8, rsp_position_now, rsp_error_now);
      end
   end

   task automatic send_delta(logic signed [pmc_pkg::DELTA_WIDTH-1:0] delta);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_encoder_delta <= delta;
      do @(posedge clock); while (!req_ready);
      sb.note_encoder_delta(delta);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic write,
                             input logic [pmc_pkg::CSR_ADDR_WIDTH-1:0] addr,
                             input logic [pmc_pkg::CSR_DATA_WIDTH-1:0] wdata,
                             output logic [pmc_pkg::CSR_DATA_WIDTH-1:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= addr;
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_register(int unsigned index, int value);
      logic [pmc_pkg::CSR_DATA_WIDTH-1:0] mask;
      logic [pmc_pkg::CSR_DATA_WIDTH-1:0] wdata;
      logic [pmc_pkg::CSR_DATA_WIDTH-1:0] readback;
      case (index)
         pmc_pkg::REG_SETPOINT:   mask = (32'd1 << pmc_pkg::SETPOINT_WIDTH) - 1;
         pmc_pkg::REG_HOLD_MOTOR: mask = 32'd1;
         default:                 mask = (32'd1 << pmc_pkg::GAIN_WIDTH) - 1;
      endcase
      wdata = (32'(value) & mask) | ($urandom() & ~mask);
      release_request();
      wait_drained();
      csr_access(1'b1, pmc_pkg::CSR_ADDR_WIDTH'(index * CSR_STRIDE), wdata, readback);
      sb.write_register(index, wdata);
      if (index <= pmc_pkg::REG_HOLD_MOTOR) begin
         csr_access(1'b0, pmc_pkg::CSR_ADDR_WIDTH'(index * CSR_STRIDE), '0, readback);
         if ((readback & mask) !== (wdata & mask)) begin
            sb.report($sformatf("register %0d reads %h after writing %h",
                                index, readback, wdata));
         end
      end
   endtask

   function automatic int pick_gain();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return GAIN_MAX;
         2, 3:    return $urandom_range(1, 64);
         default: return $urandom_range(0, GAIN_MAX);
      endcase
   endfunction

   function automatic longint clamp_delta(longint x);
      return x < -32768 ? -32768 : (x > 32767 ? 32767 : x);
   endfunction

   initial begin
      int     seg;
      int     n;
      int     kind;
      int     sp;
      longint gap;
      logic signed [pmc_pkg::DELTA_WIDTH-1:0] delta;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: all gains zero, so the drive stays at zero.
      send_delta(16'sh7fff);
      send_delta(-16'sh8000);
      send_delta(16'sd1);
      send_delta(16'sd0);

      // Dead zone edge and the friction threshold, including a rounding tie.
      program_register(pmc_pkg::REG_GAIN_P, 51);
      send_delta(-16'sd4);
      send_delta(16'sd1);
      send_delta(16'sd7);
      program_register(pmc_pkg::REG_GAIN_P, 50);
      send_delta(16'sd0);
      send_delta(-16'sd4);

      program_register(pmc_pkg::REG_GAIN_P, GAIN_MAX);
      program_register(pmc_pkg::REG_GAIN_I, GAIN_MAX);
      program_register(pmc_pkg::REG_GAIN_D, GAIN_MAX);
      program_register(pmc_pkg::REG_SETPOINT, SETPOINT_LIMIT);
      send_delta(16'sd0);
      send_delta(16'sd0);
      send_delta(16'sd0);
      send_delta(-16'sh8000);
      send_delta(16'sh7fff);
      send_delta(16'sd300);
      program_register(pmc_pkg::REG_HOLD_MOTOR, 1);
      send_delta(16'sd0);
      send_delta(-16'sd1);
      program_register(pmc_pkg::REG_HOLD_MOTOR, 0);

      program_register(pmc_pkg::REG_SETPOINT, -SETPOINT_LIMIT);
      program_register(pmc_pkg::REG_GAIN_P, 0);
      program_register(pmc_pkg::REG_GAIN_D, 0);
      program_register(pmc_pkg::REG_GAIN_I, 1);
      send_delta(16'sd0);
      send_delta(16'sd0);
      send_delta(16'sd0);
      send_delta(16'sd150);
      program_register(pmc_pkg::REG_GAIN_I, 0);
      program_register(pmc_pkg::REG_GAIN_D, GAIN_MAX);
      send_delta(16'sd100);
      send_delta(-16'sd100);
      program_register(FIRST_UNMAPPED_INDEX, -1);
      send_delta(16'sd0);

      for (seg = 0; seg < SEGMENTS; seg++) begin
         idle_on = (seg % 5) != 3;
         case ($urandom_range(0, 3))
            0:       sp = -SETPOINT_LIMIT;
            1:       sp = SETPOINT_LIMIT;
            default: sp = int'($urandom_range(0, 2 * SETPOINT_LIMIT)) - SETPOINT_LIMIT;
         endcase
         program_register(pmc_pkg::REG_GAIN_P, pick_gain());
         program_register(pmc_pkg::REG_GAIN_I, pick_gain());
         program_register(pmc_pkg::REG_GAIN_D, pick_gain());
         program_register(pmc_pkg::REG_SETPOINT, sp);
         program_register(pmc_pkg::REG_HOLD_MOTOR, $urandom_range(0, 4) == 0);
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
               delta = pmc_pkg::DELTA_WIDTH'(int'($urandom_range(0, 16)) - 8);
            end else if (kind < 75) begin
               // Steer the position back near the setpoint.
               gap = longint'(sb.target) - sb.position + int'($urandom_range(0, 6)) - 3;
               delta = pmc_pkg::DELTA_WIDTH'(clamp_delta(gap));
            end else if (kind < 90) begin
               delta = pmc_pkg::DELTA_WIDTH'(int'($urandom_range(0, 400)) - 200);
            end else begin
               delta = pmc_pkg::DELTA_WIDTH'($urandom());
            end
            send_delta(delta);
         end
      end

      // Swing the position far negative with full-scale steps and full gains,
      // so the error and the proportional term grow large, then come back.
      idle_on = 1'b0;
      program_register(pmc_pkg::REG_GAIN_P, GAIN_MAX);
      program_register(pmc_pkg::REG_GAIN_I, GAIN_MAX);
      program_register(pmc_pkg::REG_GAIN_D, GAIN_MAX);
      program_register(pmc_pkg::REG_SETPOINT, SETPOINT_LIMIT);
      program_register(pmc_pkg::REG_HOLD_MOTOR, 0);
      repeat (SWING_ITEMS) send_delta(-16'sh8000);
      repeat (SWING_ITEMS) send_delta(16'sh7fff);

      release_request();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
